// ===== hw/rtl/pwm_divider_factorizer_defines.svh =====
// Assertion macros shared by the PWM divider factorizer RTL.
// Included by pdf_ctrl, the module that carries the concurrent checks; no other dependencies.
`ifndef PWM_DIVIDER_FACTORIZER_DEFINES_SVH
`define PWM_DIVIDER_FACTORIZER_DEFINES_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset
`define PDF_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define PDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PDF_ASSERT(lbl, clk, rst_n, cond, msg)
`define PDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pdf_pkg.sv =====
// Package for the PWM divider factorizer: constants, state and command types,
// and the small prime table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdf_pkg;

    localparam int DIV_W           = 40;
    localparam int COUNT_LIMIT_DEF = 65536;
    localparam int PRIME_COUNT_DEF = 10;
    localparam int PIDX_W          = 4;

    localparam logic [31:0] CLK_RESET = 32'd48000000;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LOW = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DWAIT, S_CHECK, S_TSTART, S_TWAIT, S_FCHECK, S_FSTART,
        S_FWAIT, S_HALVE, S_CLAMP, S_MUL, S_ASTART, S_AWAIT, S_OUT
    } state_t;

    typedef enum logic [1:0] {SEL_D, SEL_TRIAL, SEL_FALL, SEL_ACH} div_sel_t;

    typedef struct packed {
        logic     load;
        logic     set_zero;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_d;
        logic     set_err;
        logic     trial_init;
        logic     small_init;
        logic     take_trial;
        logic     fall_mul;
        logic     take_fall;
        logic     halve;
        logic     clamp;
        logic     mul;
        logic     take_ach;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic f_zero;
        logic div_busy;
        logic div_done;
        logic d_small;
        logic d_big;
        logic x_end;
        logic rem_zero;
        logic q_fits;
        logic fits;
        logic p_big;
        logic out_free;
    } dp_sts_t;

    function automatic logic [4:0] prime_at(input logic [PIDX_W-1:0] i);
        logic [4:0] v;
        case (i)
            4'd0:    v = 5'd2;
            4'd1:    v = 5'd3;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd11;
            4'd5:    v = 5'd13;
            4'd6:    v = 5'd17;
            4'd7:    v = 5'd19;
            4'd8:    v = 5'd23;
            4'd9:    v = 5'd31;
            default: v = 5'd2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pdf_in_if.sv =====
// Request channel: demanded frequency word with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pdf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] demand_freq;

    modport source (output valid, output demand_freq, input ready);
    modport sink   (input valid, input demand_freq, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pdf_out_if.sv =====
// Result channel: timer setting word with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pdf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] prescale_value;
    logic [15:0] period_value;
    logic [14:0] compare_value;
    logic [31:0] achieved_freq;
    logic [1:0]  status_code;

    modport source (output valid, output prescale_value, output period_value,
                    output compare_value, output achieved_freq, output status_code,
                    input ready);
    modport sink   (input valid, input prescale_value, input period_value,
                    input compare_value, input achieved_freq, input status_code,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pdf_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, with round-half-up flag.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module pdf_div #(
    parameter int W = 40
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              busy,
    output logic              done,
    output logic [W-1:0]      quo,
    output logic [W-1:0]      rem,
    output logic              half_up
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    // Shift in one numerator bit and try a subtract
    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = diff[W] ? shifted : diff;
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign quo     = quo_reg;
    assign rem     = rem_reg[W-1:0];
    assign half_up = (rem_reg[W-1:0] >= (den_reg - rem_reg[W-1:0]));

endmodule

`default_nettype wire

// ===== hw/rtl/pdf_dp.sv =====
// Datapath: clock register, divisor, factor split, clamp, achieved frequency,
// and the result register. Depends on pdf_pkg and pdf_div.
`timescale 1ns / 1ps
`default_nettype none

module pdf_dp
    import pdf_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
    parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [31:0] wr_data,
    input  wire logic [31:0] demand_freq,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [15:0]      prescale_value,
    output logic [15:0]      period_value,
    output logic [14:0]      compare_value,
    output logic [31:0]      achieved_freq,
    output logic [1:0]       status_code
);
    localparam int XW = $clog2(PRIME_COUNT + 1);
    localparam logic [31:0] LIM  = 32'(COUNT_LIMIT);
    localparam logic [55:0] LIMM = 56'(COUNT_LIMIT);

    logic [31:0]       clk_reg;
    logic [31:0]       f_reg;
    logic [31:0]       d_reg;
    logic              sat_reg;
    logic              err_reg;
    logic [55:0]       m_reg;
    logic [31:0]       p_reg;
    logic [XW-1:0]     x_reg;
    logic [PIDX_W-1:0] best_idx_reg;
    logic [7:0]        best_rem_reg;
    logic [15:0]       pre_reg;
    logic [15:0]       per_reg;
    logic [32:0]       prod_reg;
    logic [31:0]       ach_reg;
    logic              ov_reg;
    logic [15:0]       ov_pre_reg;
    logic [15:0]       ov_per_reg;
    logic [14:0]       ov_cmp_reg;
    logic [31:0]       ov_ach_reg;
    logic [1:0]        ov_st_reg;

    logic [DIV_W-1:0]  div_num, div_den, div_q, div_r;
    logic              div_busy, div_done, div_half;
    logic [DIV_W:0]    q_rnd;
    logic [4:0]        prime_x;
    logic [4:0]        prime_b;
    logic [16:0]       m_cl, p_cl;
    logic              cl_sat;
    logic [15:0]       pre_c, per_c;
    logic [33:0]       prod_w;
    logic [16:0]       per_inc;
    logic [14:0]       cmp_w;

    assign prime_x = prime_at(PIDX_W'(x_reg));
    assign prime_b = prime_at(best_idx_reg);

    // Select divider operands for the current division
    always_comb
    begin
        case (cmd.div_sel)
            SEL_D:
            begin
                div_num = {clk_reg, 8'h00};
                div_den = {8'h00, f_reg};
            end
            SEL_TRIAL:
            begin
                div_num = {8'h00, p_reg};
                div_den = {35'd0, prime_x};
            end
            SEL_FALL:
            begin
                div_num = {8'h00, d_reg};
                div_den = m_reg[DIV_W-1:0];
            end
            default:
            begin
                div_num = {clk_reg, 8'h00};
                div_den = {7'd0, prod_reg};
            end
        endcase
    end

    pdf_div #(.W(DIV_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_q),
        .rem     (div_r),
        .half_up (div_half)
    );

    assign q_rnd = {1'b0, div_q} + (DIV_W + 1)'(div_half);

    // Clamp counts and order them so the prescaler is the smaller one
    always_comb
    begin
        cl_sat = 1'b0;
        if (m_reg > 56'd65536)
        begin
            m_cl   = 17'd65536;
            cl_sat = 1'b1;
        end
        else
        begin
            m_cl = m_reg[16:0];
        end
        if (p_reg == 32'd0)
        begin
            p_cl   = 17'd1;
            cl_sat = 1'b1;
        end
        else if (p_reg > 32'd65536)
        begin
            p_cl   = 17'd65536;
            cl_sat = 1'b1;
        end
        else
        begin
            p_cl = p_reg[16:0];
        end
        pre_c = 16'(m_cl - 17'd1);
        per_c = 16'(p_cl - 17'd1);
        if (pre_c > per_c)
        begin
            pre_c = 16'(p_cl - 17'd1);
            per_c = 16'(m_cl - 17'd1);
        end
    end

    assign prod_w  = ({1'b0, pre_reg} + 17'd1) * ({1'b0, per_reg} + 17'd1);
    assign per_inc = {1'b0, per_reg} + 17'd1;
    assign cmp_w   = (per_reg >= 16'd1) ? 15'((per_inc >> 1) - 17'd1) : 15'd0;

    // Hold the clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_reg <= CLK_RESET;
        end
        else if (wr_en)
        begin
            clk_reg <= wr_data;
        end
    end

    // Advance the working registers on controller commands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f_reg   <= demand_freq;
            sat_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        if (cmd.set_zero)
        begin
            d_reg   <= '1;
            sat_reg <= 1'b1;
        end
        if (cmd.take_d)
        begin
            if (q_rnd[DIV_W:32] != '0)
            begin
                d_reg   <= '1;
                sat_reg <= 1'b1;
            end
            else
            begin
                d_reg <= q_rnd[31:0];
            end
        end
        if (cmd.set_err)
        begin
            pre_reg <= 16'd0;
            per_reg <= 16'd1;
            ach_reg <= 32'd0;
            err_reg <= 1'b1;
        end
        if (cmd.trial_init)
        begin
            m_reg        <= 56'd1;
            p_reg        <= d_reg;
            x_reg        <= '0;
            best_idx_reg <= '0;
            best_rem_reg <= 8'd255;
        end
        if (cmd.small_init)
        begin
            m_reg <= 56'd1;
            p_reg <= d_reg;
        end
        if (cmd.take_trial)
        begin
            if (div_r == '0)
            begin
                p_reg <= div_q[31:0];
                m_reg <= 56'(m_reg * prime_x);
            end
            else
            begin
                if (div_r[7:0] <= best_rem_reg)
                begin
                    best_rem_reg <= div_r[7:0];
                    best_idx_reg <= PIDX_W'(x_reg);
                end
                x_reg <= x_reg + XW'(1);
            end
        end
        if (cmd.fall_mul)
        begin
            m_reg <= 56'(m_reg * prime_b);
        end
        if (cmd.take_fall)
        begin
            p_reg <= div_q[31:0];
        end
        if (cmd.halve)
        begin
            p_reg <= p_reg >> 1;
            m_reg <= m_reg << 1;
        end
        if (cmd.clamp)
        begin
            pre_reg <= pre_c;
            per_reg <= per_c;
            if (cl_sat)
            begin
                sat_reg <= 1'b1;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_w[32:0];
        end
        if (cmd.take_ach)
        begin
            if (q_rnd[DIV_W:32] != '0)
            begin
                ach_reg <= '1;
                sat_reg <= 1'b1;
            end
            else
            begin
                ach_reg <= q_rnd[31:0];
            end
        end
    end

    // Hold the result word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ov_pre_reg <= pre_reg;
            ov_per_reg <= per_reg;
            ov_cmp_reg <= cmp_w;
            ov_ach_reg <= ach_reg;
            ov_st_reg  <= err_reg ? ST_LOW : (sat_reg ? ST_SAT : ST_OK);
        end
    end

    assign out_valid      = ov_reg;
    assign prescale_value = ov_pre_reg;
    assign period_value   = ov_per_reg;
    assign compare_value  = ov_cmp_reg;
    assign achieved_freq  = ov_ach_reg;
    assign status_code    = ov_st_reg;

    // Report status to the controller
    always_comb
    begin
        sts.f_zero   = (f_reg == 32'd0);
        sts.div_busy = div_busy;
        sts.div_done = div_done;
        sts.d_small  = (d_reg < 32'd2);
        sts.d_big    = (d_reg > LIM);
        sts.x_end    = (x_reg == XW'(PRIME_COUNT));
        sts.rem_zero = (div_r == '0);
        sts.q_fits   = (div_q[31:0] <= LIM);
        sts.fits     = (p_reg <= LIM) && (m_reg <= LIMM);
        sts.p_big    = (p_reg > LIM);
        sts.out_free = !ov_reg || out_ready;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pdf_ctrl.sv =====
// Controller state machine sequencing the divisor, factor search, clamp and
// achieved-frequency steps. Depends on pdf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_divider_factorizer_defines.svh"

module pdf_ctrl
    import pdf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);
    state_t state_reg, state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_LOAD;
            S_LOAD:   state_next = sts.f_zero ? S_CHECK : S_DWAIT;
            S_DWAIT:  if (sts.div_done) state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.d_small)    state_next = S_OUT;
                else if (sts.d_big) state_next = S_TSTART;
                else                state_next = S_CLAMP;
            end
            S_TSTART: state_next = sts.x_end ? S_FCHECK : S_TWAIT;
            S_TWAIT:
            begin
                if (sts.div_done)
                    state_next = (sts.rem_zero && sts.q_fits) ? S_FCHECK : S_TSTART;
            end
            S_FCHECK: state_next = sts.fits ? S_CLAMP : S_FSTART;
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT:  if (sts.div_done) state_next = S_HALVE;
            S_HALVE:  if (!sts.p_big) state_next = S_CLAMP;
            S_CLAMP:  state_next = S_MUL;
            S_MUL:    state_next = S_ASTART;
            S_ASTART: state_next = S_AWAIT;
            S_AWAIT:  if (sts.div_done) state_next = S_OUT;
            S_OUT:    if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = SEL_D;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_LOAD:
            begin
                cmd.set_zero  = sts.f_zero;
                cmd.div_start = !sts.f_zero;
            end
            S_DWAIT:  cmd.take_d = sts.div_done;
            S_CHECK:
            begin
                cmd.set_err    = sts.d_small;
                cmd.trial_init = !sts.d_small && sts.d_big;
                cmd.small_init = !sts.d_small && !sts.d_big;
            end
            S_TSTART:
            begin
                cmd.div_sel   = SEL_TRIAL;
                cmd.div_start = !sts.x_end;
            end
            S_TWAIT:
            begin
                cmd.div_sel    = SEL_TRIAL;
                cmd.take_trial = sts.div_done;
            end
            S_FCHECK: cmd.fall_mul = !sts.fits;
            S_FSTART:
            begin
                cmd.div_sel   = SEL_FALL;
                cmd.div_start = 1'b1;
            end
            S_FWAIT:
            begin
                cmd.div_sel   = SEL_FALL;
                cmd.take_fall = sts.div_done;
            end
            S_HALVE:  cmd.halve = sts.p_big;
            S_CLAMP:  cmd.clamp = 1'b1;
            S_MUL:    cmd.mul = 1'b1;
            S_ASTART:
            begin
                cmd.div_sel   = SEL_ACH;
                cmd.div_start = 1'b1;
            end
            S_AWAIT:
            begin
                cmd.div_sel  = SEL_ACH;
                cmd.take_ach = sts.div_done;
            end
            S_OUT:    cmd.out_load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    `PDF_ASSERT_IMPL(a_start_idle, clk, rst_n, cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `PDF_ASSERT_IMPL(a_done_wait, clk, rst_n, sts.div_done, (state_reg == S_DWAIT || state_reg == S_TWAIT || state_reg == S_FWAIT || state_reg == S_AWAIT), "divider finished outside a wait state")
    `PDF_ASSERT_IMPL(a_out_free, clk, rst_n, cmd.out_load, sts.out_free, "result loaded over an untaken word")

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_divider_factorizer.sv =====
// PWM divider factorizer: takes a demanded frequency (Q24.8 Hz), returns a
// prescaler/period pair, duty compare, achieved frequency and status. One word
// is worked at a time by a single shared 40-bit restoring divider that yields
// one quotient bit per cycle. An item costs one division for the divisor, one
// per trial-division step (ten misses plus one per prime factor taken out),
// one for the fallback split and one for the achieved frequency. A new word
// is taken while a result still waits.
// Depends on pdf_pkg, the channel interfaces, pdf_ctrl and pdf_dp.
`timescale 1ns / 1ps
`default_nettype none

module pwm_divider_factorizer
    import pdf_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
    parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [31:0] wr_data,
    pdf_in_if.sink           req,
    pdf_out_if.source        rsp
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;

    assign req.ready = in_ready;

    pdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdf_dp #(
        .COUNT_LIMIT (COUNT_LIMIT),
        .PRIME_COUNT (PRIME_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .demand_freq    (req.demand_freq),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .prescale_value (rsp.prescale_value),
        .period_value   (rsp.period_value),
        .compare_value  (rsp.compare_value),
        .achieved_freq  (rsp.achieved_freq),
        .status_code    (rsp.status_code)
    );

endmodule

`default_nettype wire

// ===== dv/pdf_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL (pdf_in_if, pdf_out_if).
// This file holds the small helper package of word types used by tb. Depends on pdf_pkg.
`timescale 1ns / 1ps

package pdf_tb_pkg;
    import pdf_pkg::*;

    typedef struct packed {
        logic [15:0] prescale;
        logic [15:0] period;
        logic [14:0] compare;
        logic [31:0] achieved;
        logic [1:0]  status;
    } timer_word_t;
endpackage

// ===== dv/tb.sv =====
// Testbench for pwm_divider_factorizer: drives demanded frequencies, predicts the
// timer setting of each and compares every result word. Depends on pdf_pkg,
// pdf_tb_pkg, pdf_in_if, pdf_out_if and the RTL.
`timescale 1ns / 1ps

module tb;
    import pdf_pkg::*;
    import pdf_tb_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1280;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [31:0] wr_data;
    pdf_in_if  req ();
    pdf_out_if rsp ();

    pwm_divider_factorizer dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_data(wr_data), .req(req), .rsp(rsp)
    );

    logic [31:0] clock_hz;
    timer_word_t pending_words[$];
    int errors;
    int idle_cycles;
    bit all_sent;

    // Directed stimulus table: clock setting, frequency, typed result, whether typed
    typedef struct {
        logic [31:0] clk_hz;
        logic [31:0] freq;
        bit          typed;
        timer_word_t word;
    } dir_row_t;

    // Divide rounding to nearest, a half rounding up
    function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q = q + 1;
        return q;
    endfunction

    // Compute the timer setting for one demanded frequency
    function automatic timer_word_t timer_setting(input logic [31:0] hz, input logic [31:0] freq);
        logic [4:0]  primes[10];
        logic [63:0] num, d, m, p, pre, per, tmp, ach;
        logic [31:0] rm, best_rem;
        int          x, best_idx;
        logic [1:0]  st;
        timer_word_t w;
        primes = '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd31};
        num = {24'd0, hz, 8'd0};
        st = ST_OK;
        if (freq == 0)
        begin
            d = 64'hFFFF_FFFF;
            st = ST_SAT;
        end
        else
        begin
            d = round_div(num, {32'd0, freq});
            if (d > 64'hFFFF_FFFF)
            begin
                d = 64'hFFFF_FFFF;
                st = ST_SAT;
            end
        end
        if (d < 2)
        begin
            w.prescale = 0;
            w.period = 1;
            w.compare = 0;
            w.achieved = 0;
            w.status = ST_LOW;
            return w;
        end
        m = 1;
        p = d;
        if (d > 65536)
        begin
            x = 0;
            best_idx = 0;
            best_rem = 255;
            while (x < 10)
            begin
                rm = 32'(p % primes[x]);
                if (rm == 0)
                begin
                    p = p / primes[x];
                    m = m * primes[x];
                    if (p <= 65536)
                        break;
                end
                else
                begin
                    if (rm <= best_rem)
                    begin
                        best_rem = rm;
                        best_idx = x;
                    end
                    x++;
                end
            end
            if (!(p <= 65536 && m <= 65536))
            begin
                m = m * primes[best_idx];
                p = d / m;
                while (p > 65536)
                begin
                    p = p / 2;
                    m = m * 2;
                end
            end
        end
        if (m < 1) begin m = 1; st = ST_SAT; end
        if (p < 1) begin p = 1; st = ST_SAT; end
        if (m > 65536) begin m = 65536; st = ST_SAT; end
        if (p > 65536) begin p = 65536; st = ST_SAT; end
        pre = m - 1;
        per = p - 1;
        if (pre > per)
        begin
            tmp = pre;
            pre = per;
            per = tmp;
        end
        ach = round_div(num, (pre + 1) * (per + 1));
        if (ach > 64'hFFFF_FFFF)
        begin
            ach = 64'hFFFF_FFFF;
            st = ST_SAT;
        end
        w.prescale = pre[15:0];
        w.period = per[15:0];
        w.compare = (per >= 1) ? 15'((per + 1) / 2 - 1) : 15'd0;
        w.achieved = ach[31:0];
        w.status = st;
        return w;
    endfunction

    // Free-running clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Drop the request, wait until every expected word has come, then let the block settle
    task automatic drain();
        req.valid <= 0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Write the clock register while the block is idle
    task automatic set_clock(input logic [31:0] hz);
        drain();
        wr_en <= 1;
        wr_data <= hz;
        @(posedge clk);
        wr_en <= 0;
        clock_hz = hz;
    endtask

    // Random gap, mostly short, sometimes long; drop the request during a gap
    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            req.valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Offer one frequency word and record its expectation on acceptance
    task automatic send_freq(input logic [31:0] freq, input bit typed, input timer_word_t word);
        timer_word_t w;
        w = typed ? word : timer_setting(clock_hz, freq);
        req.valid <= 1;
        req.demand_freq <= freq;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_words.push_back(w);
    endtask

    // Random frequency: mostly in a sensible range, some full-width
    function automatic logic [31:0] random_freq();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 4000);
            2: return 32'($urandom_range(1, 2000)) << 8;
            3: return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
            default: return 32'($urandom_range(50, 200000)) << 8 | 32'($urandom_range(0, 255));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        dir_row_t rows[$];
        dir_row_t r;
        timer_word_t none;
        logic [31:0] clocks[6];
        none = '0;
        errors = 0;
        all_sent = 0;
        clock_hz = CLK_RESET;
        rst_n = 0;
        wr_en = 0;
        wr_data = 0;
        req.valid = 0;
        req.demand_freq = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed rows: after-reset clock, extremes and the low-divisor error
        rows.push_back('{CLK_RESET, 32'd0, 0, none});
        rows.push_back('{CLK_RESET, 32'd1, 0, none});
        rows.push_back('{CLK_RESET, 32'hFFFF_FFFF, 1,
                         '{16'd0, 16'd2, 15'd0, 32'd4096000000, ST_OK}});
        rows.push_back('{CLK_RESET, 32'd1000 << 8, 1,
                         '{16'd0, 16'd47999, 15'd23999, 32'd1000 << 8, ST_OK}});
        rows.push_back('{CLK_RESET, 32'd732 << 8, 0, none});
        rows.push_back('{CLK_RESET, 32'd733 << 8, 0, none});
        rows.push_back('{CLK_RESET, 32'd50 << 8, 0, none});
        rows.push_back('{CLK_RESET, 32'd7 << 8, 0, none});
        rows.push_back('{CLK_RESET, 32'd24000000 << 8, 0, none});
        rows.push_back('{CLK_RESET, 32'd30000000 << 8, 0, none});
        rows.push_back('{32'hFFFF_FFFF, 32'd1, 0, none});
        rows.push_back('{32'hFFFF_FFFF, 32'd0, 0, none});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_FFFF, 0, none});
        rows.push_back('{32'd1, 32'd0, 0, none});
        rows.push_back('{32'd1, 32'd128, 1, '{16'd0, 16'd1, 15'd0, 32'd128, ST_OK}});
        rows.push_back('{32'd1, 32'd200, 1, '{16'd0, 16'd1, 15'd0, 32'd0, ST_LOW}});
        rows.push_back('{32'd1000003, 32'd1, 0, none});
        rows.push_back('{32'd65536, 32'd256, 0, none});
        rows.push_back('{32'd65537, 32'd256, 0, none});
        rows.push_back('{32'd2147483647, 32'd3, 0, none});
        rows.push_back('{32'd123456789, 32'hAAAA_AAAA, 0, none});
        rows.push_back('{32'd123456789, 32'h5555_5555, 0, none});
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.clk_hz != clock_hz)
                set_clock(r.clk_hz);
            send_freq(r.freq, r.typed, r.word);
            random_gap();
        end

        // Random part over several clock settings, extremes among them
        clocks = '{32'd1, 32'hFFFF_FFFF, CLK_RESET, 32'd72000000, 32'd0, 32'd16000000};
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 160 == 0)
                set_clock((i / 160 < 6) ? clocks[i / 160] : $urandom());
            if (i == 700)
                drain();
            send_freq(random_freq(), 0, none);
            random_gap();
        end
        req.valid <= 0;
        all_sent = 1;
    end

    // Result sink with random stalls
    initial
    begin
        rsp.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 19) == 0)
                rsp.ready <= 0;
            else if ($urandom_range(0, 2) != 0)
                rsp.ready <= 1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        timer_word_t want;
        timer_word_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.prescale_value, rsp.period_value, rsp.compare_value,
                    rsp.achieved_freq, rsp.status_code};
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake, and the end of the run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
            if (all_sent && pending_words.size() == 0)
            begin
                repeat (50) @(posedge clk);
                if (errors == 0 && pending_words.size() == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
        end
    end
endmodule

// ===== pwm_divider_factorizer.f =====
+incdir+hw/rtl
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_in_if.sv
hw/rtl/pdf_out_if.sv
hw/rtl/pdf_div.sv
hw/rtl/pdf_dp.sv
hw/rtl/pdf_ctrl.sv
hw/rtl/pwm_divider_factorizer.sv
dv/pdf_tb_if.sv
dv/tb.sv
